// ===== src/multitap_feedback_reverb_assert.svh =====
// assertion helpers shared by the reverb rtl
// both expect clk and rst_n in scope
`ifndef MULTITAP_FEEDBACK_REVERB_ASSERT_SVH
`define MULTITAP_FEEDBACK_REVERB_ASSERT_SVH

// same-cycle implication
`define MTFR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MTFR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mtfr_pkg.sv =====
package mtfr_pkg;

  localparam int SW        = 32;
  localparam int IN_W      = 16;
  localparam int CODE_W    = 8;
  localparam int TAPS      = 4;
  localparam int TAP_OFS [TAPS] = '{1557, 2801, 4409, 4000};
  localparam int TAP_PCT [TAPS] = '{35, 25, 18, 12};
  localparam int PCT_SCALE = 100;
  localparam int FB_AHEAD  = 100;
  localparam int DECAY_NUM = 9;
  localparam int DECAY_DEN = 2550;
  localparam int SEND_DEN  = 255;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CMD    = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN
  } seq_state_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_FB,
    RD_T0,
    RD_T1,
    RD_T2,
    RD_T3
  } rd_sel_t;

  typedef enum logic {
    A_DRY,
    A_RAM
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SEND,
    B_DECAY,
    B_G0,
    B_G1,
    B_G2,
    B_G3
  } b_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_SUM,
    OUT_DRY
  } out_sel_t;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t STEP_BYPASS = 3'd7;

  typedef struct packed {
    rd_sel_t  rd;
    a_sel_t   a;
    b_sel_t   b;
    logic     mul_en;
    acc_op_t  wb;
    acc_op_t  wet;
    logic     mem_wr;
    out_sel_t out;
    logic     jmp_byp;
    step_t    jmp_to;
  } uword_t;

  // control store: one word per program step
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{rd: RD_NONE, a: A_DRY, b: B_SEND, mul_en: 1'b0, wb: ACC_NONE,
          wet: ACC_NONE, mem_wr: 1'b0, out: OUT_NONE, jmp_byp: 1'b0, jmp_to: '0};
    case (s)
      3'd0: begin
        w.rd = RD_FB;  w.a = A_DRY; w.b = B_SEND; w.mul_en = 1'b1;
        w.jmp_byp = 1'b1; w.jmp_to = STEP_BYPASS;
      end
      3'd1: begin
        w.rd = RD_T0;  w.a = A_RAM; w.b = B_DECAY; w.mul_en = 1'b1; w.wb = ACC_LOAD;
      end
      3'd2: begin
        w.rd = RD_T1;  w.a = A_RAM; w.b = B_G0; w.mul_en = 1'b1; w.wb = ACC_ADD;
      end
      3'd3: begin
        w.rd = RD_T2;  w.a = A_RAM; w.b = B_G1; w.mul_en = 1'b1; w.wet = ACC_LOAD;
        w.mem_wr = 1'b1;
      end
      3'd4: begin
        w.rd = RD_T3;  w.a = A_RAM; w.b = B_G2; w.mul_en = 1'b1; w.wet = ACC_ADD;
      end
      3'd5: begin
        w.a = A_RAM; w.b = B_G3; w.mul_en = 1'b1; w.wet = ACC_ADD;
      end
      3'd6: begin
        w.out = OUT_SUM;
      end
      3'd7: begin
        w.out = OUT_DRY;
      end
      default: begin
        w.out = OUT_DRY;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== src/multitap_feedback_reverb.sv =====
// per-channel stereo reverb: four delay taps plus one feedback path per channel
// in_*: one request is either a gain command (in_op = 1) or a stereo frame (in_op = 0).
//   a command sets decay/send gains of in_chan and gives no result.
//   a frame gives exactly one result on out_*, dry << FRAC_BITS plus weighted taps
//   (dry alone when bypassed). a frame with nonzero send runs a 7-step control
//   program, and in_ready stays low until its result is registered. the delay
//   memory has one read and one write port; each step reads one stereo row
//   (feedback row, then four tap rows). a frame with zero send, or an unused
//   channel, jumps from the first step to the dry pass-through step.
// reset: gains and positions clear at once, then the delay memory is swept to
//   zero, one row a cycle, all CHANNELS*DELAY_LENGTH rows (65536 by default);
//   in_ready stays low during the sweep.
// stall: the result waits in the output register; a later program parks on its last
//   step, with in_ready low, until out_ready takes the pending result.
module multitap_feedback_reverb #(
  parameter int CHANNELS     = 8,
  parameter int DELAY_LENGTH = 8192,
  parameter int FRAC_BITS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [2:0]          in_chan,
  input  logic signed [15:0]  in_dry_left,
  input  logic signed [15:0]  in_dry_right,
  input  logic [15:0]         in_command_value,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_left,
  output logic signed [31:0]  out_right
);

  import mtfr_pkg::*;

  localparam int GW   = FRAC_BITS + 1;
  localparam int DW   = FRAC_BITS;
  localparam int PW   = $clog2(DELAY_LENGTH);
  localparam int ROWS = CHANNELS * DELAY_LENGTH;
  localparam int AW   = $clog2(ROWS);
  localparam int CIW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PRW  = SW + GW + 1;
  localparam int LUTN = 2 ** CODE_W;

  localparam logic [PW:0] LEN    = (PW+1)'(DELAY_LENGTH);
  localparam logic [PW:0] FB_OFF = (PW+1)'(FB_AHEAD % DELAY_LENGTH);
  localparam logic [PW:0] TAP_OFF [TAPS] = '{
    (PW+1)'(TAP_OFS[0] % DELAY_LENGTH), (PW+1)'(TAP_OFS[1] % DELAY_LENGTH),
    (PW+1)'(TAP_OFS[2] % DELAY_LENGTH), (PW+1)'(TAP_OFS[3] % DELAY_LENGTH)};
  localparam logic [GW-1:0] TAP_GAIN [TAPS] = '{
    GW'((TAP_PCT[0] << FRAC_BITS) / PCT_SCALE), GW'((TAP_PCT[1] << FRAC_BITS) / PCT_SCALE),
    GW'((TAP_PCT[2] << FRAC_BITS) / PCT_SCALE), GW'((TAP_PCT[3] << FRAC_BITS) / PCT_SCALE)};

  typedef logic [GW-1:0] send_lut_t [LUTN];
  typedef logic [DW-1:0] decay_lut_t [LUTN];

  function automatic send_lut_t build_send_lut();
    send_lut_t t;
    for (int i = 0; i < LUTN; i++) begin
      t[i] = GW'((i << FRAC_BITS) / SEND_DEN);
    end
    return t;
  endfunction

  function automatic decay_lut_t build_decay_lut();
    decay_lut_t t;
    for (int i = 0; i < LUTN; i++) begin
      t[i] = DW'(((i * DECAY_NUM) << FRAC_BITS) / DECAY_DEN);
    end
    return t;
  endfunction

  localparam send_lut_t  SEND_LUT  = build_send_lut();
  localparam decay_lut_t DECAY_LUT = build_decay_lut();

  // sequencer state
  seq_state_t state_r, state_nxt;
  step_t      step_r, step_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic       out_valid_r, out_valid_nxt;
  uword_t     uw;
  logic       adv;
  logic       accept, in_range;
  logic [CIW-1:0] ch_idx;

  // per-channel state
  logic [PW-1:0] pos_r   [CHANNELS];
  logic [DW-1:0] decay_r [CHANNELS];
  logic [GW-1:0] send_r  [CHANNELS];

  // item registers
  logic [CIW-1:0]   ch_r;
  logic [AW-1:0]    base_r;
  logic             byp_r;
  logic signed [SW-1:0] dry_lt_r, dry_rt_r;
  logic signed [SW-1:0] prod_lt_r, prod_rt_r;
  logic signed [SW-1:0] wb_lt_r, wb_rt_r;
  logic signed [SW-1:0] wet_lt_r, wet_rt_r;
  logic signed [SW-1:0] out_lt_r, out_rt_r;

  // datapath
  logic [PW-1:0] cur_pos;
  logic [DW-1:0] cur_decay;
  logic [GW-1:0] cur_send;
  logic [PW:0]   pos_ext, back_off, fwd, bwd;
  logic          use_fwd;
  logic [PW-1:0] rd_pos;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [2*SW-1:0] ram_wdata, ram_rdata;
  logic signed [SW-1:0] rd_lt, rd_rt, mul_a_lt, mul_a_rt;
  logic [GW-1:0]  mul_b;
  logic signed [PRW-1:0] pf_lt, pf_rt;
  logic signed [SW-1:0] dry_lt_in, dry_rt_in;

  assign accept   = in_valid && in_ready;
  assign in_range = int'(in_chan) < CHANNELS;
  assign ch_idx   = in_range ? CIW'(in_chan) : '0;
  assign in_ready = (state_r == ST_IDLE);
  assign uw       = ucode(step_r);
  assign adv      = !((uw.out != OUT_NONE) && out_valid_r && !out_ready);

  assign cur_pos   = pos_r[ch_r];
  assign cur_decay = decay_r[ch_r];
  assign cur_send  = send_r[ch_r];

  assign dry_lt_in = SW'(in_dry_left) <<< FRAC_BITS;
  assign dry_rt_in = SW'(in_dry_right) <<< FRAC_BITS;

  // read position: ahead for feedback, behind for taps, both modulo the line
  always_comb begin
    use_fwd  = 1'b0;
    back_off = TAP_OFF[0];
    case (uw.rd)
      RD_FB:   use_fwd = 1'b1;
      RD_T0:   back_off = TAP_OFF[0];
      RD_T1:   back_off = TAP_OFF[1];
      RD_T2:   back_off = TAP_OFF[2];
      RD_T3:   back_off = TAP_OFF[3];
      default: back_off = TAP_OFF[0];
    endcase
    pos_ext = {1'b0, cur_pos};
    fwd     = pos_ext + FB_OFF;
    bwd     = pos_ext + LEN - back_off;
    if (use_fwd) begin
      rd_pos = (fwd >= LEN) ? PW'(fwd - LEN) : PW'(fwd);
    end else begin
      rd_pos = (bwd >= LEN) ? PW'(bwd - LEN) : PW'(bwd);
    end
  end

  assign rd_addr = base_r + AW'(rd_pos);
  assign wr_addr = base_r + AW'(cur_pos);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wr_addr;
    ram_wdata = {wb_rt_r, wb_lt_r};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (state_r == ST_RUN && uw.mem_wr) begin
      ram_we = 1'b1;
    end
  end

  mtfr_ram #(
    .WIDTH (2 * SW),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (state_r == ST_RUN),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign rd_lt = ram_rdata[SW-1:0];
  assign rd_rt = ram_rdata[2*SW-1:SW];

  // shared multiplier pair, product floored by the arithmetic shift
  always_comb begin
    mul_a_lt = (uw.a == A_RAM) ? rd_lt : dry_lt_r;
    mul_a_rt = (uw.a == A_RAM) ? rd_rt : dry_rt_r;
    case (uw.b)
      B_SEND:  mul_b = cur_send;
      B_DECAY: mul_b = GW'(cur_decay);
      B_G0:    mul_b = TAP_GAIN[0];
      B_G1:    mul_b = TAP_GAIN[1];
      B_G2:    mul_b = TAP_GAIN[2];
      B_G3:    mul_b = TAP_GAIN[3];
      default: mul_b = '0;
    endcase
  end

  assign pf_lt = PRW'(mul_a_lt) * PRW'($signed({1'b0, mul_b}));
  assign pf_rt = PRW'(mul_a_rt) * PRW'($signed({1'b0, mul_b}));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_op == OP_SAMPLE) begin
          state_nxt = ST_RUN;
          step_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          if (uw.out != OUT_NONE) begin
            state_nxt     = ST_IDLE;
            out_valid_nxt = 1'b1;
          end else if (uw.jmp_byp && byp_r) begin
            step_nxt = uw.jmp_to;
          end else begin
            step_nxt = step_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_addr_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      step_r      <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // gains and write positions
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pos_r[c]   <= '0;
        decay_r[c] <= '0;
        send_r[c]  <= '0;
      end
    end else begin
      if (accept && in_op == OP_CMD && in_range) begin
        decay_r[ch_idx] <= DECAY_LUT[in_command_value[15:8]];
        send_r[ch_idx]  <= SEND_LUT[in_command_value[7:0]];
      end
      if (state_r == ST_RUN && uw.out == OUT_SUM && adv) begin
        pos_r[ch_r] <= (pos_ext == LEN - 1'b1) ? '0 : cur_pos + 1'b1;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (accept && in_op == OP_SAMPLE) begin
      ch_r     <= ch_idx;
      base_r   <= AW'(int'(ch_idx) * DELAY_LENGTH);
      byp_r    <= !in_range || (send_r[ch_idx] == '0);
      dry_lt_r <= dry_lt_in;
      dry_rt_r <= dry_rt_in;
    end
    if (state_r == ST_RUN) begin
      if (uw.mul_en) begin
        prod_lt_r <= pf_lt[FRAC_BITS +: SW];
        prod_rt_r <= pf_rt[FRAC_BITS +: SW];
      end
      case (uw.wb)
        ACC_LOAD: begin
          wb_lt_r <= prod_lt_r;
          wb_rt_r <= prod_rt_r;
        end
        ACC_ADD: begin
          wb_lt_r <= wb_lt_r + prod_lt_r;
          wb_rt_r <= wb_rt_r + prod_rt_r;
        end
        default: ;
      endcase
      case (uw.wet)
        ACC_LOAD: begin
          wet_lt_r <= prod_lt_r;
          wet_rt_r <= prod_rt_r;
        end
        ACC_ADD: begin
          wet_lt_r <= wet_lt_r + prod_lt_r;
          wet_rt_r <= wet_rt_r + prod_rt_r;
        end
        default: ;
      endcase
      if (adv) begin
        case (uw.out)
          OUT_SUM: begin
            out_lt_r <= dry_lt_r + wet_lt_r + prod_lt_r;
            out_rt_r <= dry_rt_r + wet_rt_r + prod_rt_r;
          end
          OUT_DRY: begin
            out_lt_r <= dry_lt_r;
            out_rt_r <= dry_rt_r;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_left  = out_lt_r;
  assign out_right = out_rt_r;

`include "multitap_feedback_reverb_assert.svh"

  `MTFR_ASSERT_NXT(a_sample_runs, accept && in_op == OP_SAMPLE, state_r == ST_RUN, "sample request did not start the program")
  `MTFR_ASSERT_NXT(a_cmd_no_run, accept && in_op == OP_CMD, state_r == ST_IDLE, "command request started the program")
  `MTFR_ASSERT_IMP(a_clear_quiet, state_r == ST_CLEAR, !out_valid_r && !in_ready, "activity during memory sweep")
  `MTFR_ASSERT_IMP(a_out_from_prog, $rose(out_valid_r), $past(state_r == ST_RUN), "result appeared outside the program")

endmodule

// ===== src/mtfr_ram.sv =====
module mtfr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
